// ----- hw/rtl/srm_pkg.sv -----
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants of the scaler rate meter
// Field widths, alarm codes, register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package srm_pkg;

    localparam int COUNT_W  = 64;
    localparam int TIME_W   = 48;
    localparam int RATE_W   = 48;
    localparam int STATUS_W = 2;
    localparam int HALF_W   = 32;
    localparam int MULT_W   = 10;

    // Hz per count per millisecond
    localparam logic [MULT_W-1:0] RATE_MULT = 10'd1000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ALARM_OFF  = 2'd0,
        ALARM_OK   = 2'd1,
        ALARM_LOW  = 2'd2,
        ALARM_HIGH = 2'd3
    } t_alarm;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_UPDATE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic div_rate;
        logic div_mean;
        logic cap_rate;
        logic cap_mean;
        logic win_update;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic take;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/srm_ifs.sv -----
// ----------------------------------------------------------------------------
// srm_ifs: item channels of the scaler rate meter
// Refresh channel (count and timestamp) and result channel (rate and alarm).
// ----------------------------------------------------------------------------
interface srm_in_if;
    import srm_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] event_count;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output event_count, output now_ms, input ready);
    modport sink   (input valid, input event_count, input now_ms, output ready);
endinterface

interface srm_out_if;
    import srm_pkg::*;

    logic                valid;
    logic                ready;
    logic [RATE_W-1:0]   rate;
    logic [STATUS_W-1:0] alarm_status;

    modport source (output valid, output rate, output alarm_status, input ready);
    modport sink   (input valid, input rate, input alarm_status, output ready);
endinterface

// ----- hw/rtl/srm_ram.sv -----
// ----------------------------------------------------------------------------
// srm_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module srm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/srm_div.sv -----
// ----------------------------------------------------------------------------
// srm_div: restoring divider, one quotient bit per cycle
// Quotient keeps the low 48 bits; any higher quotient bit sets the saturate flag.
// ----------------------------------------------------------------------------
module srm_div #(
    parameter int DVD_W = 82,
    parameter int CNT_W = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DVD_W-1:0]           i_dividend,
    input  logic [srm_pkg::RATE_W-1:0] i_divisor,
    input  logic [CNT_W-1:0]           i_steps,
    output logic [srm_pkg::RATE_W-1:0] o_quotient,
    output logic                       o_sat,
    output logic                       o_done
);
    import srm_pkg::*;

    logic [DVD_W-1:0]  r_dvd;
    logic [RATE_W-1:0] r_dvs;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_quo;
    logic              r_sat;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [RATE_W:0]   rem_sh;
    logic [RATE_W:0]   diff;
    logic              ge;
    logic [RATE_W-1:0] n_rem;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[RATE_W-2:0], ge};
            r_sat <= r_sat | r_quo[RATE_W-1];
        end
    end

    assign o_quotient = r_quo;
    assign o_sat      = r_sat;
    assign o_done     = r_done;
endmodule

// ----- hw/rtl/srm_dp.sv -----
// ----------------------------------------------------------------------------
// srm_dp: datapath of the scaler rate meter
// Snapshot, shared 32x10 multiplier, divider, rate window, running total,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module srm_dp #(
    parameter int HISTORY_DEPTH      = 8,
    parameter int RATE_FRACTION_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srm_pkg::t_dp_cmd              i_cmd,
    output srm_pkg::t_dp_stat             o_stat,
    input  logic [srm_pkg::COUNT_W-1:0]   i_event_count,
    input  logic [srm_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                          i_cfg_we,
    input  logic [srm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srm_pkg::RATE_W-1:0]    i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [srm_pkg::RATE_W-1:0]    o_rate,
    output logic [srm_pkg::STATUS_W-1:0]  o_alarm_status
);
    import srm_pkg::*;

    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int TOT_W   = RATE_W + $clog2(HISTORY_DEPTH);
    localparam int PART_W  = HALF_W + MULT_W;
    localparam int PROD_W  = COUNT_W + MULT_W;
    localparam int DVD_W   = PROD_W + RATE_FRACTION_BITS;
    localparam int CNT_W   = $clog2(DVD_W + 1);
    localparam int MEAN_SH = DVD_W - TOT_W;

    logic [TIME_W-1:0]   r_last_time;
    logic [COUNT_W-1:0]  r_last_count;
    logic [COUNT_W-1:0]  r_delta;
    logic [TIME_W-1:0]   r_dt;
    logic                r_take;
    logic [PART_W-1:0]   r_prod_lo;
    logic [PART_W-1:0]   r_prod_hi;
    logic [RATE_W-1:0]   r_inst;
    logic [FILL_W-1:0]   r_fill;
    logic [SLOT_W-1:0]   r_slot;
    logic [TOT_W-1:0]    r_total;
    logic [RATE_W-1:0]   r_avg;
    logic                r_alarm_en;
    logic [RATE_W-1:0]   r_low_limit;
    logic [RATE_W-1:0]   r_high_limit;
    logic                r_out_valid;
    logic [RATE_W-1:0]   r_out_rate;
    t_alarm              r_out_status;

    logic [HALF_W-1:0]   mul_op;
    logic [PART_W-1:0]   mul_res;
    logic [PROD_W-1:0]   prod;
    logic [DVD_W-1:0]    div_dvd;
    logic [RATE_W-1:0]   div_dvs;
    logic [CNT_W-1:0]    div_steps;
    logic                div_start;
    logic [RATE_W-1:0]   div_quo;
    logic                div_sat;
    logic                div_done;
    logic [RATE_W-1:0]   old_rate;
    logic                win_full;
    logic [TOT_W-1:0]    n_total;
    logic [SLOT_W-1:0]   n_slot;
    t_alarm              alarm;

    // one 32x10 multiplier, low half then high half of the count delta
    always_comb begin
        mul_op  = i_cmd.mul_hi ? r_delta[COUNT_W-1:HALF_W] : r_delta[HALF_W-1:0];
        mul_res = PART_W'(mul_op) * PART_W'(RATE_MULT);
        prod    = PROD_W'(r_prod_lo) + {r_prod_hi, {HALF_W{1'b0}}};
    end

    // rate: (delta * 1000) << frac over elapsed ms; mean: total over fill,
    // left-aligned so that only the total's own bits are stepped through
    always_comb begin
        div_start = i_cmd.div_rate | i_cmd.div_mean;
        if (i_cmd.div_mean) begin
            div_dvd   = DVD_W'(r_total) << MEAN_SH;
            div_dvs   = RATE_W'(r_fill);
            div_steps = CNT_W'(TOT_W);
        end else begin
            div_dvd   = DVD_W'(prod) << RATE_FRACTION_BITS;
            div_dvs   = r_dt;
            div_steps = CNT_W'(DVD_W);
        end
    end

    srm_div #(
        .DVD_W (DVD_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_steps    (div_steps),
        .o_quotient (div_quo),
        .o_sat      (div_sat),
        .o_done     (div_done)
    );

    srm_ram #(
        .WIDTH (RATE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_update),
        .i_waddr (r_slot),
        .i_wdata (r_inst),
        .i_raddr (r_slot),
        .o_rdata (old_rate)
    );

    // drop the oldest entry once the window is full, add the new one
    always_comb begin
        win_full = (r_fill == FILL_W'(HISTORY_DEPTH));
        n_total  = r_total - (win_full ? TOT_W'(old_rate) : '0) + TOT_W'(r_inst);
        n_slot   = (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    // low check wins over high check
    always_comb begin
        if (!r_alarm_en) begin
            alarm = ALARM_OFF;
        end else if ((r_low_limit != '0) && (r_avg < r_low_limit)) begin
            alarm = ALARM_LOW;
        end else if ((r_high_limit != '0) && (r_avg > r_high_limit)) begin
            alarm = ALARM_HIGH;
        end else begin
            alarm = ALARM_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_last_count <= '0;
            r_take <= 1'b0;
            r_fill <= '0;
            r_slot <= '0;
            r_total <= '0;
            r_avg <= '0;
            r_alarm_en <= 1'b0;
            r_low_limit <= '0;
            r_high_limit <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_take <= (r_last_time != '0) && (i_now_ms > r_last_time);
                r_last_time <= i_now_ms;
                r_last_count <= i_event_count;
            end
            if (i_cmd.win_update) begin
                r_total <= n_total;
                r_slot <= n_slot;
                if (!win_full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (i_cmd.cap_mean) begin
                r_avg <= div_quo;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ALARM_EN:   r_alarm_en <= i_cfg_wdata[0];
                    REG_LOW_LIMIT:  r_low_limit <= i_cfg_wdata;
                    REG_HIGH_LIMIT: r_high_limit <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_delta <= i_event_count - r_last_count;
            r_dt <= i_now_ms - r_last_time;
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= mul_res;
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= mul_res;
        end
        if (i_cmd.cap_rate) begin
            r_inst <= div_sat ? '1 : div_quo;
        end
        if (i_cmd.out_load) begin
            r_out_rate <= r_avg;
            r_out_status <= alarm;
        end
    end

    assign o_stat.take     = r_take;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_rate         = r_out_rate;
    assign o_alarm_status = r_out_status;
endmodule

// ----- hw/rtl/srm_ctrl.sv -----
// ----------------------------------------------------------------------------
// srm_ctrl: sequencer of the scaler rate meter
// Steps one refresh item through multiply, divide, window update and mean.
// ----------------------------------------------------------------------------
module srm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  srm_pkg::t_dp_stat  i_stat,
    output srm_pkg::t_dp_cmd   o_cmd,
    output srm_pkg::t_state    o_state
);
    import srm_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;
    logic    in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.take ? ST_MUL_LO : ST_FINISH;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                n_state = ST_RATE_GO;
            end
            ST_RATE_GO: begin
                cmd.div_rate = 1'b1;
                n_state = ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.cap_rate = 1'b1;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.win_update = 1'b1;
                n_state = ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
                cmd.div_mean = 1'b1;
                n_state = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.cap_mean = 1'b1;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = in_ready;
    assign o_state    = r_state;
endmodule

// ----- hw/rtl/scaler_rate_meter_with_alarm.sv -----
// ----------------------------------------------------------------------------
// scaler_rate_meter_with_alarm: windowed scaler rate with low/high alarm
// Turns refresh items (cumulative count, ms timestamp) into an averaged rate
// in Hz with RATE_FRACTION_BITS fraction bits and a 2-bit alarm status.
// ----------------------------------------------------------------------------
// Every refresh item yields exactly one result item. When a snapshot exists
// (stored time nonzero) and time advanced, the instant rate
// (delta_count * 1000 << RATE_FRACTION_BITS) / elapsed_ms, saturated to 48
// bits, enters a window of the last HISTORY_DEPTH rates, and the result rate
// is the truncated mean of the window; otherwise the previous rate repeats.
// The snapshot is overwritten on every item. Alarm status: 0 disabled, 1 ok,
// 2 below the low threshold, 3 above the high threshold; the low check wins,
// a zero threshold turns its check off. One item is in flight at a time. Both
// divisions of a refresh that adds a rate run on one shared restoring divider
// at one bit per cycle, over DVD_W = 74 + RATE_FRACTION_BITS and then
// TOT_W = 48 + clog2(HISTORY_DEPTH) dividend bits. A finished result sits in
// an output register; the next item is accepted while it waits to be taken.
// Configuration (index 0 alarm enable, 1 low threshold, 2 high threshold) is
// written through i_cfg_we / i_cfg_index / i_cfg_wdata; other indexes are
// ignored.
// ----------------------------------------------------------------------------
module scaler_rate_meter_with_alarm #(
    parameter int HISTORY_DEPTH      = 8,
    parameter int RATE_FRACTION_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    srm_in_if.sink                        i_in,
    srm_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [srm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srm_pkg::RATE_W-1:0]    i_cfg_wdata
);
    import srm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_state   state;
    logic     in_ready;

    // sequencer: owns the input handshake and issues datapath commands
    srm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    // datapath: snapshot, arithmetic, window and the result register
    srm_dp #(
        .HISTORY_DEPTH      (HISTORY_DEPTH),
        .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_event_count  (i_in.event_count),
        .i_now_ms       (i_in.now_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_rate         (o_out.rate),
        .o_alarm_status (o_out.alarm_status)
    );

    assign i_in.ready = in_ready;

    // hold off new items for the whole time one is being worked on
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again right after an accept");

    // divider results arrive only when the sequencer waits for one
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_done |-> (state == ST_RATE_WAIT || state == ST_MEAN_WAIT))
        else $error("divider finished outside a wait state");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register loaded while still full");

    // one result for each accepted item: loading implies an item was in flight
    a_load_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !i_in.ready)
        else $error("result loaded while idle");
endmodule

// ----- test/scaler_rate_meter_with_alarm_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaler_rate_meter_with_alarm_tb: self-checking regression of the rate meter
// Feeds refresh items (cumulative count, ms timestamp) through the input
// channel and predicts each averaged rate and alarm status in a scoreboard
// that keeps its own snapshot, rate window and alarm thresholds. Results are
// checked in order, field by field, with random idling on both channels in most phases.
// ----------------------------------------------------------------------------
module scaler_rate_meter_with_alarm_tb;
    import srm_pkg::*;

    localparam int HISTORY     = 8;
    localparam int FRAC_BITS   = 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 800;
    localparam int DRAIN_WAIT  = 300;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 10;
    localparam int SUM_W       = RATE_W + 3;

    // Index that maps to no register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [RATE_W-1:0]  RATE_TOP  = '1;
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
    localparam logic [TIME_W-1:0]  TIME_TOP  = '1;

    // One expected result item.
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        t_alarm            status;
    } t_reading;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the meter state plus the queue of expected items.
    // ------------------------------------------------------------------------
    class rate_alarm_tracker;
        bit                alarm_on;
        bit [RATE_W-1:0]   low_limit;
        bit [RATE_W-1:0]   high_limit;
        bit [TIME_W-1:0]   snap_time;
        bit [COUNT_W-1:0]  snap_count;
        bit [RATE_W-1:0]   rate_hist [HISTORY];
        int unsigned       hist_fill;
        int unsigned       hist_slot;
        bit [SUM_W-1:0]    hist_sum;
        bit [RATE_W-1:0]   mean_rate;
        t_reading          expected_readings [$];
        int unsigned       mismatches;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
            case (idx)
                REG_ALARM_EN:   alarm_on   = data[0];
                REG_LOW_LIMIT:  low_limit  = data;
                REG_HIGH_LIMIT: high_limit = data;
                default: ;
            endcase
        endfunction

        // Counts per ms scaled to Hz with fraction bits; clamp at the top.
        function bit [RATE_W-1:0] instant_rate(bit [COUNT_W-1:0] delta,
                                               bit [TIME_W-1:0] span);
            bit [81:0] scaled;
            bit [81:0] quot;
            scaled = 82'(delta) * (82'(RATE_MULT) << FRAC_BITS);
            quot   = scaled / 82'(span);
            if (quot[81:RATE_W] != 0) begin
                return RATE_TOP;
            end
            return quot[RATE_W-1:0];
        endfunction

        function void note_refresh(bit [COUNT_W-1:0] count, bit [TIME_W-1:0] now);
            bit [RATE_W-1:0] fresh;
            bit [SUM_W-1:0]  quot;
            t_reading        exp;
            if (snap_time != 0 && now > snap_time) begin
                fresh = instant_rate(count - snap_count, now - snap_time);
                if (hist_fill >= HISTORY) begin
                    hist_sum -= SUM_W'(rate_hist[hist_slot]);
                end
                rate_hist[hist_slot] = fresh;
                hist_sum += SUM_W'(fresh);
                hist_slot = (hist_slot + 1) % HISTORY;
                if (hist_fill < HISTORY) begin
                    hist_fill++;
                end
                quot      = hist_sum / SUM_W'(hist_fill);
                mean_rate = quot[RATE_W-1:0];
            end
            snap_time  = now;
            snap_count = count;
            exp.rate = mean_rate;
            if (!alarm_on) begin
                exp.status = ALARM_OFF;
            end else if (low_limit != 0 && mean_rate < low_limit) begin
                exp.status = ALARM_LOW;
            end else if (high_limit != 0 && mean_rate > high_limit) begin
                exp.status = ALARM_HIGH;
            end else begin
                exp.status = ALARM_OK;
            end
            expected_readings.insert(expected_readings.size(), exp);
        endfunction

        function void check_reading(logic [RATE_W-1:0] rate, logic [STATUS_W-1:0] status);
            t_reading exp;
            if (expected_readings.size() == 0) begin
                $error("unexpected result item: rate %0d alarm_status %0d", rate, status);
                mismatches++;
                return;
            end
            exp = expected_readings[0];
            expected_readings.delete(0);
            if (rate !== exp.rate) begin
                $error("rate: expected %0d, actual %0d", exp.rate, rate);
                mismatches++;
            end
            if (status !== exp.status) begin
                $error("alarm_status: expected %0d, actual %0d", exp.status, status);
                mismatches++;
            end
        endfunction

        function int unsigned waiting();
            return expected_readings.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [RATE_W-1:0]     i_cfg_wdata;

    srm_in_if  in_ch ();
    srm_out_if out_ch ();

    rate_alarm_tracker tracker = new();

    // Traffic knobs shared by the driving processes.
    bit              src_idle_on;
    bit              sink_idle_on;
    bit              hold_results;
    bit [COUNT_W-1:0] cur_count;
    bit [TIME_W-1:0]  cur_time;
    int              cycle_count;

    scaler_rate_meter_with_alarm #(
        .HISTORY_DEPTH      (HISTORY),
        .RATE_FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the traffic never drains.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("scaler_rate_meter_with_alarm regression: fail");
        $finish;
    end

    function automatic bit [TIME_W-1:0] random_word48();
        bit [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Offer one refresh item and hold it until taken; then maybe go idle.
    // Leave valid high when the next item follows back to back.
    task automatic send_refresh(input bit [COUNT_W-1:0] count, input bit [TIME_W-1:0] now);
        in_ch.valid       <= 1'b1;
        in_ch.event_count <= count;
        in_ch.now_ms      <= now;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_refresh(count, now);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Write one register; the write enable stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // Wait for every expected result, then load a new alarm setting.
    task automatic settle_and_configure(input logic [RATE_W-1:0] en_word,
                                        input logic [RATE_W-1:0] low,
                                        input logic [RATE_W-1:0] high);
        while (tracker.waiting() != 0) @(posedge i_clk);
        write_reg(REG_ALARM_EN, en_word);
        write_reg(REG_LOW_LIMIT, low);
        write_reg(REG_HIGH_LIMIT, high);
        write_reg(REG_UNUSED, random_word48());
        i_cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly steady refresh runs near a chosen rate so the
    // window fills and wraps, plus arbitrary noise and broken runs where time
    // stands still, steps back, or the count wraps around.
    task automatic run_mix(input int n_items);
        int         sent;
        int         pick;
        int         len;
        int         level;
        int         span;
        bit [TIME_W-1:0] step;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                len   = $urandom_range(4, 30);
                level = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1 << 20)
                                                    : $urandom_range(0, 500);
                span  = $urandom_range(1, 2000);
                repeat (len) begin
                    step      = TIME_W'($urandom_range(1, span));
                    cur_time  += step;
                    cur_count += (64'(level) * 64'(step)) / 1000
                                 + COUNT_W'($urandom_range(0, 2));
                    send_refresh(cur_count, cur_time);
                    sent++;
                end
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    cur_count = {$urandom, $urandom};
                    cur_time  = ($urandom_range(0, 3) == 0) ? '0 : random_word48();
                    send_refresh(cur_count, cur_time);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 2))
                        0: ;  // same timestamp again
                        1: cur_time -= TIME_W'($urandom_range(1, 5000));
                        default: begin
                            cur_time  += TIME_W'($urandom_range(1, 50));
                            cur_count -= COUNT_W'($urandom_range(1, 1000));
                        end
                    endcase
                    send_refresh(cur_count, cur_time);
                    sent++;
                end
            end
        end
    endtask

    // Result side: take items, stall in random bursts, and on request hold
    // off long enough for the meter to back up onto its input.
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_reading(out_ch.rate, out_ch.alarm_status);
            end
            if (hold_results) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_results = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed refreshes, then phases of random traffic
    // under different alarm settings.
    initial begin
        logic [RATE_W-1:0] en_word;
        logic [RATE_W-1:0] low;
        logic [RATE_W-1:0] high;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= REG_ALARM_EN;
        i_cfg_wdata       <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.event_count <= '0;
        in_ch.now_ms      <= '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_results = 1'b0;
        cur_count    = '0;
        cur_time     = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero timestamps under reset settings: no snapshot, alarm disabled.
        send_refresh(64'd5, '0);
        send_refresh(64'd7, '0);

        // Alarm on, 500 Hz .. 2000 Hz band.
        in_ch.valid <= 1'b0;
        settle_and_configure(48'd1, 48'd500 << FRAC_BITS, 48'd2000 << FRAC_BITS);
        send_refresh(64'd100, 48'd1000);         // first snapshot, no rate yet
        send_refresh(64'd1100, 48'd2000);        // exactly 1000 Hz
        send_refresh(64'd2000, 48'd2000);        // time did not advance
        send_refresh(64'd3000, 48'd1500);        // time stepped back
        send_refresh(64'd3000, 48'd1501);        // no counts: zero rate, mean on the floor
        send_refresh(COUNT_TOP, 48'd1502);       // huge delta saturates the rate
        send_refresh(64'd5, 48'd1503);           // count wraps around
        send_refresh(COUNT_TOP, TIME_TOP);       // widest elapsed time
        send_refresh(COUNT_TOP, 48'd1);          // back to the start of time
        send_refresh(64'd0, 48'd2);              // wrap by one count
        // Walk the window past its depth at a steady rate.
        for (int k = 1; k <= 10; k++) begin
            send_refresh(64'(k), 48'(k + 2));
        end
        in_ch.valid <= 1'b0;

        cur_count = {$urandom, $urandom};
        cur_time  = random_word48();

        for (int p = 0; p < NUM_PHASES; p++) begin
            en_word = 48'd1;
            low     = 48'($urandom_range(50, 250)) << FRAC_BITS;
            high    = 48'($urandom_range(250, 450)) << FRAC_BITS;
            case (p)
                0: begin
                    en_word = random_word48() & ~48'd1;  // stray upper bits, alarm off
                    low     = random_word48();
                    high    = random_word48();
                end
                1: begin
                    low  = '0;
                    high = '0;
                end
                3: begin
                    low  = RATE_TOP;  // both checks hold: the low one wins
                    high = 48'd1;
                end
                4: begin
                    low  = '0;
                    high = 48'd1;
                end
                5: begin
                    en_word = random_word48() | 48'd1;
                    low     = random_word48();
                    high    = random_word48();
                end
                6: begin
                    low  = 48'd1;
                    high = RATE_TOP;
                end
                default: ;
            endcase
            src_idle_on  = (p < NUM_PHASES - 2) && (p != 3);
            sink_idle_on = src_idle_on;
            settle_and_configure(en_word, low, high);
            if (p == 5) begin
                hold_results = 1'b1;
            end
            run_mix(PHASE_ITEMS);
            in_ch.valid <= 1'b0;
        end

        while (tracker.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("scaler_rate_meter_with_alarm regression: pass");
        end else begin
            $display("scaler_rate_meter_with_alarm regression: fail");
        end
        $finish;
    end

endmodule
